/* design/unit_direction_between_points_defines.svh */
// Assertion helpers shared by the checker.
`ifndef UNIT_DIRECTION_BETWEEN_POINTS_DEFINES_SVH
`define UNIT_DIRECTION_BETWEEN_POINTS_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define UDBP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define UDBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/udbp_pkg.sv */
`default_nettype none
package udbp_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int OUT_WIDTH   = 16;

  localparam int DW     = COORD_WIDTH + 1;          // exact difference width
  localparam int PW     = $clog2(DW);               // msb index width
  localparam int NW     = 24;                       // normalized magnitude width
  localparam int SQW    = 2 * NW + 1;               // sum of squares width
  localparam int SQ_SH  = 14;                       // radicand pre-shift
  localparam int RADW   = 2 * ((SQW + SQ_SH + 1) / 2);
  localparam int ROOTW  = RADW / 2;                 // one root bit per cell
  localparam int REMW   = ROOTW + 2;
  localparam int FRAC   = OUT_WIDTH - 1;
  localparam int QB     = OUT_WIDTH + 1;            // quotient bits, one per cell
  localparam int NUMW   = NW + FRAC + 8;
  localparam int DREMW  = ROOTW + 1;
  localparam int LATENCY = 4 + ROOTW + 1 + QB + 1;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_a_x;
    logic signed [COORD_WIDTH-1:0] point_a_y;
    logic signed [COORD_WIDTH-1:0] point_b_x;
    logic signed [COORD_WIDTH-1:0] point_b_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] dir_x;
    logic signed [OUT_WIDTH-1:0] dir_y;
    logic                        same_point;
  } out_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic same;
  } tag_t;

  typedef struct packed {
    logic [NW-1:0] mag_a;
    logic [NW-1:0] mag_b;
    tag_t          tag;
  } side_t;

  typedef struct packed {
    logic [RADW-1:0]  rad;
    logic [REMW-1:0]  rem;
    logic [ROOTW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [QB-1:0]    bits_x;
    logic [QB-1:0]    bits_y;
    logic [DREMW-1:0] rem_x;
    logic [DREMW-1:0] rem_y;
    logic [QB-1:0]    q_x;
    logic [QB-1:0]    q_y;
    logic [ROOTW-1:0] len;
  } div_t;

  // Move the leading one of v to bit NW-1, truncating on a right shift.
  function automatic logic [NW-1:0] norm_shift(logic [DW-1:0] v, logic [PW-1:0] p);
    logic [DW+NW-1:0] tmp;
    tmp = {{NW{1'b0}}, v};
    if (int'(p) >= NW - 1) begin
      tmp = tmp >> (int'(p) - (NW - 1));
    end else begin
      tmp = tmp << ((NW - 1) - int'(p));
    end
    return tmp[NW-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/udbp_sqrt_cell.sv */
`default_nettype none
module udbp_sqrt_cell import udbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  side_t side_i,
  input  sqrt_t sq_i,
  output logic  valid_o,
  output side_t side_o,
  output sqrt_t sq_o
);

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;
  sqrt_t           sq_d;

  // One root bit: bring down two radicand bits, try root*4+1.
  always_comb begin
    rem_sh     = {sq_i.rem[REMW-3:0], sq_i.rad[RADW-1 -: 2]};
    trial      = {sq_i.root, 2'b01};
    ge         = rem_sh >= trial;
    sq_d.rad   = {sq_i.rad[RADW-3:0], 2'b00};
    sq_d.rem   = ge ? rem_sh - trial : rem_sh;
    sq_d.root  = {sq_i.root[ROOTW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_i;
    sq_o   <= sq_d;
  end

endmodule
`default_nettype wire

/* design/udbp_div_cell.sv */
`default_nettype none
module udbp_div_cell import udbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  tag_t tag_i,
  input  div_t dv_i,
  output logic valid_o,
  output tag_t tag_o,
  output div_t dv_o
);

  logic [DREMW-1:0] sh_x;
  logic [DREMW-1:0] sh_y;
  logic [DREMW-1:0] divisor;
  logic             ge_x;
  logic             ge_y;
  div_t             dv_d;

  // One quotient bit for each component against the shared length.
  always_comb begin
    divisor     = {1'b0, dv_i.len};
    sh_x        = {dv_i.rem_x[DREMW-2:0], dv_i.bits_x[QB-1]};
    sh_y        = {dv_i.rem_y[DREMW-2:0], dv_i.bits_y[QB-1]};
    ge_x        = sh_x >= divisor;
    ge_y        = sh_y >= divisor;
    dv_d.bits_x = {dv_i.bits_x[QB-2:0], 1'b0};
    dv_d.bits_y = {dv_i.bits_y[QB-2:0], 1'b0};
    dv_d.rem_x  = ge_x ? sh_x - divisor : sh_x;
    dv_d.rem_y  = ge_y ? sh_y - divisor : sh_y;
    dv_d.q_x    = {dv_i.q_x[QB-2:0], ge_x};
    dv_d.q_y    = {dv_i.q_y[QB-2:0], ge_y};
    dv_d.len    = dv_i.len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_o <= tag_i;
    dv_o  <= dv_d;
  end

endmodule
`default_nettype wire

/* design/unit_direction_between_points.sv */
// Pipeline: 4 front stages, 32 square-root cells with one root bit each, one setup
//   stage, 17 divider cells with one quotient bit each, and one output stage that
//   registers done_o and rsp_o together. Throughput: one word per cycle; busy stays low,
//   start may stay high.
// The receiver cannot stall: each result shows for exactly one cycle on done_o.
// Reset clears only the valid bits of the pipe; no words are in flight after it.
`default_nettype none
module unit_direction_between_points import udbp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  req_i,
  output logic done_o,
  output out_t rsp_o
);

  // Pipe never blocks: every start is taken.
  assign busy = 1'b0;

  // ---------------- stage 1: exact differences, sign and magnitude
  logic signed [DW-1:0] dx_c;
  logic signed [DW-1:0] dy_c;
  logic                 s1_v_q;
  logic [DW-1:0]        s1_mx_q;
  logic [DW-1:0]        s1_my_q;
  logic                 s1_nx_q;
  logic                 s1_ny_q;

  always_comb begin
    dx_c = $signed({req_i.point_a_x[COORD_WIDTH-1], req_i.point_a_x})
         - $signed({req_i.point_b_x[COORD_WIDTH-1], req_i.point_b_x});
    dy_c = $signed({req_i.point_a_y[COORD_WIDTH-1], req_i.point_a_y})
         - $signed({req_i.point_b_y[COORD_WIDTH-1], req_i.point_b_y});
  end

  always_ff @(posedge clk_i) begin
    s1_nx_q <= dx_c[DW-1];
    s1_ny_q <= dy_c[DW-1];
    s1_mx_q <= dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
    s1_my_q <= dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
  end

  // ---------------- stage 2: normalize the larger magnitude to [2^23, 2^24)
  logic [DW-1:0] m_c;
  logic [PW-1:0] msb_c;
  logic          s2_v_q;
  side_t         s2_q;

  always_comb begin
    m_c   = (s1_mx_q > s1_my_q) ? s1_mx_q : s1_my_q;
    msb_c = '0;
    for (int i = 0; i < DW; i++) begin
      if (m_c[i]) begin
        msb_c = PW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q.mag_a     <= norm_shift(s1_mx_q, msb_c);
    s2_q.mag_b     <= norm_shift(s1_my_q, msb_c);
    s2_q.tag.neg_x <= s1_nx_q;
    s2_q.tag.neg_y <= s1_ny_q;
    s2_q.tag.same  <= (m_c == '0);
  end

  // ---------------- stage 3: squares
  logic          s3_v_q;
  side_t         s3_side_q;
  logic [2*NW-1:0] s3_sqa_q;
  logic [2*NW-1:0] s3_sqb_q;

  always_ff @(posedge clk_i) begin
    s3_side_q <= s2_q;
    s3_sqa_q  <= s2_q.mag_a * s2_q.mag_a;
    s3_sqb_q  <= s2_q.mag_b * s2_q.mag_b;
  end

  // ---------------- stage 4: sum of squares, scaled radicand
  logic [SQW-1:0] sum_c;
  logic           s4_v_q;
  side_t          s4_side_q;
  sqrt_t          s4_sq_q;

  assign sum_c = SQW'(s3_sqa_q) + SQW'(s3_sqb_q);

  always_ff @(posedge clk_i) begin
    s4_side_q    <= s3_side_q;
    s4_sq_q.rad  <= RADW'({sum_c, {SQ_SH{1'b0}}});
    s4_sq_q.rem  <= '0;
    s4_sq_q.root <= '0;
  end

  // ---------------- square-root chain, one root bit per cell
  logic  sq_v    [0:ROOTW];
  side_t sq_side [0:ROOTW];
  sqrt_t sq_dat  [0:ROOTW];

  assign sq_v[0]    = s4_v_q;
  assign sq_side[0] = s4_side_q;
  assign sq_dat[0]  = s4_sq_q;

  for (genvar g = 0; g < ROOTW; g++) begin : g_sqrt
    udbp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_v[g]),
      .side_i  (sq_side[g]),
      .sq_i    (sq_dat[g]),
      .valid_o (sq_v[g+1]),
      .side_o  (sq_side[g+1]),
      .sq_o    (sq_dat[g+1])
    );
  end

  // ---------------- divider setup: numerator = c * 2^(F+7) + floor(L/2)
  logic [ROOTW-1:0] len_c;
  logic [NUMW-1:0]  num_x_c;
  logic [NUMW-1:0]  num_y_c;
  logic             s5_v_q;
  tag_t             s5_tag_q;
  div_t             s5_dv_q;

  always_comb begin
    len_c   = sq_dat[ROOTW].root;
    num_x_c = NUMW'({sq_side[ROOTW].mag_a, {(FRAC + 7){1'b0}}}) + NUMW'(len_c >> 1);
    num_y_c = NUMW'({sq_side[ROOTW].mag_b, {(FRAC + 7){1'b0}}}) + NUMW'(len_c >> 1);
  end

  always_ff @(posedge clk_i) begin
    s5_tag_q       <= sq_side[ROOTW].tag;
    s5_dv_q.bits_x <= num_x_c[QB-1:0];
    s5_dv_q.bits_y <= num_y_c[QB-1:0];
    s5_dv_q.rem_x  <= DREMW'(num_x_c[NUMW-1:QB]);
    s5_dv_q.rem_y  <= DREMW'(num_y_c[NUMW-1:QB]);
    s5_dv_q.q_x    <= '0;
    s5_dv_q.q_y    <= '0;
    s5_dv_q.len    <= len_c;
  end

  // ---------------- divider chain, one quotient bit per cell
  logic dv_v   [0:QB];
  tag_t dv_tag [0:QB];
  div_t dv_dat [0:QB];

  assign dv_v[0]   = s5_v_q;
  assign dv_tag[0] = s5_tag_q;
  assign dv_dat[0] = s5_dv_q;

  for (genvar g = 0; g < QB; g++) begin : g_div
    udbp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_v[g]),
      .tag_i   (dv_tag[g]),
      .dv_i    (dv_dat[g]),
      .valid_o (dv_v[g+1]),
      .tag_o   (dv_tag[g+1]),
      .dv_o    (dv_dat[g+1])
    );
  end

  // ---------------- output: saturate, apply sign, zero the coincident case
  localparam logic [QB-1:0] QONE = QB'(1) << FRAC;
  logic [QB-1:0]        qx_c;
  logic [QB-1:0]        qy_c;
  logic [OUT_WIDTH-1:0] ox_c;
  logic [OUT_WIDTH-1:0] oy_c;
  tag_t                 tag_c;

  always_comb begin
    tag_c = dv_tag[QB];
    qx_c  = dv_dat[QB].q_x;
    qy_c  = dv_dat[QB].q_y;
    if (tag_c.neg_x) begin
      if (qx_c > QONE) qx_c = QONE;
      ox_c = OUT_WIDTH'(-qx_c);
    end else begin
      if (qx_c > QONE - 1'b1) qx_c = QONE - 1'b1;
      ox_c = OUT_WIDTH'(qx_c);
    end
    if (tag_c.neg_y) begin
      if (qy_c > QONE) qy_c = QONE;
      oy_c = OUT_WIDTH'(-qy_c);
    end else begin
      if (qy_c > QONE - 1'b1) qy_c = QONE - 1'b1;
      oy_c = OUT_WIDTH'(qy_c);
    end
    if (tag_c.same) begin
      ox_c = '0;
      oy_c = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_o.dir_x      <= ox_c;
    rsp_o.dir_y      <= oy_c;
    rsp_o.same_point <= tag_c.same;
  end

  // Valid bits of the front stages, the setup stage and the output strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= sq_v[ROOTW];
      done_o <= dv_v[QB];
    end
  end

endmodule
`default_nettype wire

/* design/udbp_checker.sv */
`default_nettype none
`include "unit_direction_between_points_defines.svh"
module udbp_checker import udbp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input in_t  req_i,
  input logic done_o,
  input out_t rsp_o
);

  logic same_in;
  logic zero_out;

  assign same_in  = (req_i.point_a_x == req_i.point_b_x)
                 && (req_i.point_a_y == req_i.point_b_y);
  assign zero_out = (rsp_o.dir_x == '0) && (rsp_o.dir_y == '0);

  `UDBP_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
  `UDBP_ASSERT_IMP(a_done_from_start, done_o, $past(start, LATENCY), "word without start")
  `UDBP_ASSERT_IMP(a_same_zero, done_o && rsp_o.same_point, zero_out, "nonzero on same point")
  `UDBP_ASSERT_IMP(a_unit_nonzero, done_o && !rsp_o.same_point, !zero_out, "zero direction")
  `UDBP_ASSERT_IMP(a_same_match, done_o, rsp_o.same_point == $past(same_in, LATENCY), "same")

endmodule

bind unit_direction_between_points udbp_checker u_udbp_checker (.*);
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;
  import udbp_pkg::*;

  // Pipeline depth of the block, plus margin for the drain.
  localparam int PIPE_DEPTH   = 55;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 20;
  // Idle-cycle limit: longest sender gap plus the pipe, taken several times over.
  localparam int IDLE_LIMIT   = 2000;
  localparam int N_RANDOM     = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  req_i = '0;
  logic done_o;
  out_t rsp_o;

  unit_direction_between_points dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Words waiting to be driven, and directions still owed by the block.
  in_t  point_pairs[$];
  out_t pending_dirs[$];

  int   mismatches = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_same = 0;
  int   idle_cycles = 0;
  bit   stim_done = 1'b0;
  bit   hold_sender = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;

  // Integer square root by bit pairs, floor.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Round one magnitude against the length, then saturate and apply the sign.
  function automatic logic signed [OUT_WIDTH-1:0] scale_component(
      logic [63:0] mag, bit neg, logic [63:0] len);
    logic [63:0] q;
    logic [63:0] one;
    one = 64'd1 << FRAC;
    q = ((mag << (FRAC + 7)) + (len >> 1)) / len;
    if (neg) begin
      if (q > one) q = one;
      return OUT_WIDTH'(-q);
    end
    if (q > one - 1) q = one - 1;
    return OUT_WIDTH'(q);
  endfunction

  function automatic out_t unit_direction(in_t p);
    out_t r;
    longint dx;
    longint dy;
    bit nx;
    bit ny;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    logic [63:0] len;
    dx = longint'(p.point_a_x) - longint'(p.point_b_x);
    dy = longint'(p.point_a_y) - longint'(p.point_b_y);
    nx = dx < 0;
    ny = dy < 0;
    a = nx ? -dx : dx;
    b = ny ? -dy : dy;
    r = '0;
    if (a == 0 && b == 0) begin
      r.same_point = 1'b1;
      return r;
    end
    m = (a > b) ? a : b;
    // Normalize the larger magnitude into [2^23, 2^24).
    while (m >= (64'd1 << 24)) begin
      a = a >> 1; b = b >> 1; m = m >> 1;
    end
    while (m < (64'd1 << 23)) begin
      a = a << 1; b = b << 1; m = m << 1;
    end
    len = floor_sqrt((a * a + b * b) << 14);
    if (len == 0) len = 1;
    r.dir_x = scale_component(a, nx, len);
    r.dir_y = scale_component(b, ny, len);
    return r;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      1: return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      2: return COORD_WIDTH'($signed($urandom_range(0, 64)) - 32);
      default: return COORD_WIDTH'($urandom);
    endcase
  endfunction

  function automatic in_t make_pair(int ax, int ay, int bx, int by);
    in_t p;
    p.point_a_x = COORD_WIDTH'(ax);
    p.point_a_y = COORD_WIDTH'(ay);
    p.point_b_x = COORD_WIDTH'(bx);
    p.point_b_y = COORD_WIDTH'(by);
    return p;
  endfunction

  // Driver: bursts of random length separated by random gaps; the word is
  // accepted at an edge where start is high and busy is low.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        pending_dirs.push_back(unit_direction(req_i));
        n_sent++;
        void'(point_pairs.pop_front());
      end
      if (start && busy) begin
        // hold the current word until accepted
      end else if (point_pairs.size() - ((start && !busy) ? 0 : 0) > 0 && !hold_sender &&
                   gap_left == 0) begin
        start <= 1'b1;
        req_i <= point_pairs[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: each strobe carries one direction, compared with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        idle_cycles = 0;
        if (pending_dirs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: dir_x=%0d dir_y=%0d same=%0b",
                     rsp_o.dir_x, rsp_o.dir_y, rsp_o.same_point);
        end else begin
          out_t exp_dir;
          exp_dir = pending_dirs.pop_front();
          n_checked++;
          if (exp_dir.same_point) n_same++;
          if (rsp_o.dir_x !== exp_dir.dir_x || rsp_o.dir_y !== exp_dir.dir_y ||
              rsp_o.same_point !== exp_dir.same_point) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp (%0d,%0d,%0b) got (%0d,%0d,%0b)",
                       exp_dir.dir_x, exp_dir.dir_y, exp_dir.same_point,
                       rsp_o.dir_x, rsp_o.dir_y, rsp_o.same_point);
          end
        end
      end else if (start && !busy) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    int mx;
    int mn;
    mx = (1 <<< (COORD_WIDTH - 1)) - 1;
    mn = -(1 <<< (COORD_WIDTH - 1));
    // Directed words: coinciding points, axes, diagonals, extremes, tiny steps.
    point_pairs.push_back(make_pair(0, 0, 0, 0));
    point_pairs.push_back(make_pair(mx, mn, mx, mn));
    point_pairs.push_back(make_pair(1, 0, 0, 0));
    point_pairs.push_back(make_pair(-1, 0, 0, 0));
    point_pairs.push_back(make_pair(0, 1, 0, 0));
    point_pairs.push_back(make_pair(0, -1, 0, 0));
    point_pairs.push_back(make_pair(1, 1, 0, 0));
    point_pairs.push_back(make_pair(-1, -1, 0, 0));
    point_pairs.push_back(make_pair(mx, mx, mn, mn));
    point_pairs.push_back(make_pair(mn, mn, mx, mx));
    point_pairs.push_back(make_pair(mx, 0, mn, 0));
    point_pairs.push_back(make_pair(mn, 0, mx, 0));
    point_pairs.push_back(make_pair(0, mn, 0, mx));
    point_pairs.push_back(make_pair(mx, mn, mn, mx));
    point_pairs.push_back(make_pair(3, 4, 0, 0));
    point_pairs.push_back(make_pair(-4, 3, 0, 0));
    point_pairs.push_back(make_pair(mx, 1, mn, 0));
    point_pairs.push_back(make_pair(-1, 0, -1, 0));
    point_pairs.push_back(make_pair(-1, -1, 0, 0));
    point_pairs.push_back(make_pair(1, 3, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (point_pairs.size() == 0);
    // Hold the sender until the pipe has drained completely.
    hold_sender = 1'b1;
    wait (pending_dirs.size() == 0);
    hold_sender = 1'b0;

    for (int i = 0; i < N_RANDOM; i++) begin
      in_t p;
      p.point_a_x = rand_coord();
      p.point_a_y = rand_coord();
      case ($urandom_range(0, 9))
        0: begin p.point_b_x = p.point_a_x; p.point_b_y = p.point_a_y; end
        1: begin
          p.point_b_x = COORD_WIDTH'(p.point_a_x + $urandom_range(0, 2) - 1);
          p.point_b_y = p.point_a_y;
        end
        default: begin p.point_b_x = rand_coord(); p.point_b_y = rand_coord(); end
      endcase
      point_pairs.push_back(p);
    end
    wait (point_pairs.size() == 0);
    wait (pending_dirs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Checked %0d directions from %0d point pairs, %0d with coinciding points.",
             n_checked, n_sent, n_same);
    if (mismatches == 0 && pending_dirs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
